FILE: hdl/stanley_path_tracking_controller_top_macros.svh
// ----------------------------------------------------------------------------
// Stanley path tracking controller assertion macros
// Concurrent property wrappers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef STANLEY_PATH_TRACKING_CONTROLLER_TOP_MACROS_SVH
`define STANLEY_PATH_TRACKING_CONTROLLER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define SPT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// antecedent implies consequent in the next cycle
`define SPT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SPT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define SPT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: hdl/spt_pkg.sv
// ----------------------------------------------------------------------------
// Stanley path tracking controller package
// Sizes, register indexes, fixed-point constants and small helper functions
// ----------------------------------------------------------------------------
package spt_pkg;

    // path store geometry
    localparam int PATH_DEPTH = 256;
    localparam int PTR_W      = $clog2(PATH_DEPTH);
    localparam int LEN_W      = ($clog2(PATH_DEPTH + 1) > 9) ? $clog2(PATH_DEPTH + 1) : 9;

    // configuration register indexes
    typedef logic [2:0] t_cfg_idx;
    localparam t_cfg_idx CFG_PATH_LEN   = 3'd0;
    localparam t_cfg_idx CFG_CT_GAIN    = 3'd1;
    localparam t_cfg_idx CFG_SPEED_REF  = 3'd2;
    localparam t_cfg_idx CFG_STEER_GAIN = 3'd3;
    localparam t_cfg_idx CFG_REACH      = 3'd4;
    localparam t_cfg_idx CFG_STEER_LIM  = 3'd5;

    // fixed-point constants
    localparam logic [30:0]        SAT31        = 31'h7FFF_FFFF;
    localparam logic [30:0]        NEAR_LIMIT   = 31'd655360000;
    localparam logic [13:0]        PI_Q12       = 14'd12868;
    localparam logic signed [15:0] HALF_PI_Q12  = 16'sd6434;
    localparam logic [30:0]        EINV_Q32     = 31'd1580030168;
    localparam logic [19:0]        USEC_PER_SEC = 20'd1000000;
    localparam logic [4:0]         CORDIC_LAST  = 5'd16;
    localparam logic [4:0]         TAYLOR_LAST  = 5'd16;

    // cordic arctangent table, Q16 radians
    function automatic logic [15:0] cordic_angle(input logic [4:0] i);
        logic [15:0] a;
        unique case (i)
            5'd0:    a = 16'd51472;
            5'd1:    a = 16'd30385;
            5'd2:    a = 16'd16055;
            5'd3:    a = 16'd8150;
            5'd4:    a = 16'd4091;
            5'd5:    a = 16'd2047;
            5'd6:    a = 16'd1024;
            5'd7:    a = 16'd512;
            5'd8:    a = 16'd256;
            5'd9:    a = 16'd128;
            5'd10:   a = 16'd64;
            5'd11:   a = 16'd32;
            5'd12:   a = 16'd16;
            5'd13:   a = 16'd8;
            5'd14:   a = 16'd4;
            5'd15:   a = 16'd2;
            5'd16:   a = 16'd1;
            default: a = 16'd0;
        endcase
        return a;
    endfunction

    // magnitude of a coordinate difference, saturated to 31 bits
    function automatic logic [30:0] abs_sat31(input logic signed [33:0] d);
        logic [33:0] m;
        m = (d < 0) ? 34'(-d) : 34'(d);
        return (m > 34'(SAT31)) ? SAT31 : m[30:0];
    endfunction

endpackage

FILE: hdl/stanley_path_tracking_controller_top.sv
// ----------------------------------------------------------------------------
// Stanley path tracking controller
// Waypoint store in block memories and a multi-cycle sequencer that runs
// distance, steering law and damped speed command on shared iterative units
// ----------------------------------------------------------------------------
//  channel   handshake                 word
//  input     i_valid / o_ready         func, load fields, pose fields
//  result    o_valid / i_ready         steer_rate, speed_cmd, cross_track, index
//  config    i_cfg_valid / o_cfg_ready register index and data, always ready
//
//  a pose word runs the restoring divider (one quotient bit a cycle), the 32-step
//  square root and, unless the speed is zero, one 1/e step per integer unit of
//  ten times the heading error; the Taylor series calls the divider sixteen times.
//  synchronous active-low reset clears the pointer, held heading, state and
//  result valid flag and loads the configuration defaults; the path store is
//  not cleared. a waiting result stalls the next pose at the end.
// ----------------------------------------------------------------------------
`include "stanley_path_tracking_controller_top_macros.svh"

module stanley_path_tracking_controller_top import spt_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_func,
    input  logic [7:0]         i_load_index,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic signed [15:0] i_point_heading,
    input  logic signed [31:0] i_odom_x,
    input  logic signed [31:0] i_odom_y,
    input  logic signed [15:0] i_robot_heading,
    input  logic signed [31:0] i_frame_offset_x,
    input  logic signed [31:0] i_frame_offset_y,
    input  logic [19:0]        i_elapsed_us,
    // result channel
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_steer_rate,
    output logic [30:0]        o_speed_cmd,
    output logic signed [31:0] o_cross_track,
    output logic [7:0]         o_target_index,
    // configuration channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  t_cfg_idx           i_cfg_index,
    input  logic [30:0]        i_cfg_data
);

    // sequencer states
    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_DIFF  = 5'd1;
    localparam logic [4:0] S_SQX   = 5'd2;
    localparam logic [4:0] S_SQY   = 5'd3;
    localparam logic [4:0] S_SQSUM = 5'd4;
    localparam logic [4:0] S_SQRT  = 5'd5;
    localparam logic [4:0] S_DIST  = 5'd6;
    localparam logic [4:0] S_POST  = 5'd7;
    localparam logic [4:0] S_KE    = 5'd8;
    localparam logic [4:0] S_DIV   = 5'd9;
    localparam logic [4:0] S_CINIT = 5'd10;
    localparam logic [4:0] S_CORD  = 5'd11;
    localparam logic [4:0] S_CATAN = 5'd12;
    localparam logic [4:0] S_STEER = 5'd13;
    localparam logic [4:0] S_CLAMP = 5'd14;
    localparam logic [4:0] S_QMUL  = 5'd15;
    localparam logic [4:0] S_EXP0  = 5'd16;
    localparam logic [4:0] S_TMUL  = 5'd17;
    localparam logic [4:0] S_TACC  = 5'd18;
    localparam logic [4:0] S_EXPN  = 5'd19;
    localparam logic [4:0] S_EINV  = 5'd20;
    localparam logic [4:0] S_SPD1  = 5'd21;
    localparam logic [4:0] S_SPD2  = 5'd22;
    localparam logic [4:0] S_SPD3  = 5'd23;
    localparam logic [4:0] S_DONE  = 5'd24;

    // configuration registers
    logic [8:0]  r_path_len;
    logic [15:0] r_ct_gain;
    logic [15:0] r_speed_ref;
    logic [15:0] r_steer_gain;
    logic [30:0] r_reach;
    logic [14:0] r_steer_lim;

    // path store
    logic [31:0] r_path_x [PATH_DEPTH];
    logic [31:0] r_path_y [PATH_DEPTH];
    logic [15:0] r_path_h [PATH_DEPTH];
    logic signed [31:0] r_mx, r_my;
    logic signed [15:0] r_mh;

    // control
    logic [4:0]         r_state, n_state;
    logic [4:0]         r_ret;
    logic [5:0]         r_cnt;
    logic [4:0]         r_ci;
    logic [4:0]         r_k;
    logic [PTR_W-1:0]   r_ptr;
    logic [PTR_W-1:0]   r_idx;
    logic signed [15:0] r_held;
    logic               r_ovalid;

    // pose and distance
    logic signed [32:0] r_rx, r_ry;
    logic signed [31:0] r_offy;
    logic signed [15:0] r_rhead;
    logic [19:0]        r_elapsed;
    logic [30:0]        r_ax, r_ay;
    logic               r_negy;
    logic [61:0]        r_prod;
    logic [62:0]        r_acc;
    logic [63:0]        r_res, r_bit;
    logic [30:0]        r_dist;
    logic signed [31:0] r_e;
    logic signed [16:0] r_he;
    logic signed [48:0] r_ke;
    logic               r_argneg;

    // divider
    logic [51:0] r_dn;
    logic [19:0] r_dr, r_dd;

    // cordic and steering
    logic signed [49:0] r_cx, r_cy;
    logic signed [18:0] r_cz;
    logic signed [15:0] r_at;
    logic signed [34:0] r_p;
    logic signed [15:0] r_omega;

    // speed
    logic [50:0]        r_q;
    logic [4:0]         r_n;
    logic [11:0]        r_f;
    logic [32:0]        r_term;
    logic signed [34:0] r_sum;
    logic [32:0]        r_kv;
    logic [51:0]        r_sa;
    logic [64:0]        r_pb;
    logic [30:0]        r_speed;

    // result register
    logic signed [15:0] r_o_steer;
    logic [30:0]        r_o_speed;
    logic signed [31:0] r_o_ct;
    logic [7:0]         r_o_idx;

    // combinational helpers
    logic               w_in_acc;
    logic [LEN_W-1:0]   w_len, w_last, w_nxt;
    logic [PTR_W-1:0]   w_idx;
    logic               w_load_wr, w_pose_go;
    logic [63:0]        w_trial;
    logic               w_sq_ge;
    logic               w_near, w_reach;
    logic signed [31:0] w_e;
    logic signed [15:0] w_th;
    logic [47:0]        w_ke_mag;
    logic [20:0]        w_rsh;
    logic               w_dge;
    logic signed [49:0] w_ys, w_xs;
    logic signed [18:0] w_ang, w_zc;
    logic [14:0]        w_atm;
    logic signed [17:0] w_hsum;
    logic signed [34:0] w_lim;
    logic signed [15:0] w_omega;
    logic [16:0]        w_ahe;
    logic               w_speed_zero;
    logic [16:0]        w_xexp;
    logic [44:0]        w_tprod;
    logic signed [34:0] w_term_s;
    logic [64:0]        w_einv;
    logic [52:0]        w_spd;

    assign o_ready        = (r_state == S_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_valid        = r_ovalid;
    assign o_steer_rate   = r_o_steer;
    assign o_speed_cmd    = r_o_speed;
    assign o_cross_track  = r_o_ct;
    assign o_target_index = r_o_idx;

    // path length, current waypoint and accept decode
    always_comb begin
        w_in_acc  = i_valid & o_ready;
        w_len     = (LEN_W'(r_path_len) > LEN_W'(PATH_DEPTH)) ? LEN_W'(PATH_DEPTH)
                                                              : LEN_W'(r_path_len);
        w_last    = w_len - LEN_W'(1);
        w_idx     = (LEN_W'(r_ptr) > w_last) ? w_last[PTR_W-1:0] : r_ptr;
        w_load_wr = w_in_acc & ~i_func & (int'(i_load_index) < PATH_DEPTH);
        w_pose_go = w_in_acc & i_func & (w_len != '0);
    end

    // square root, distance decisions and cross-track error
    always_comb begin
        w_trial  = r_res + r_bit;
        w_sq_ge  = {1'b0, r_acc} >= w_trial;
        w_near   = r_dist < NEAR_LIMIT;
        w_reach  = r_dist < r_reach;
        w_nxt    = ((LEN_W'(r_idx) + LEN_W'(1)) < w_len) ? (LEN_W'(r_idx) + LEN_W'(1)) : w_last;
        if (!w_near) begin
            w_e = signed'({1'b0, NEAR_LIMIT});
        end else if (r_negy) begin
            w_e = -signed'({1'b0, r_dist});
        end else begin
            w_e = signed'({1'b0, r_dist});
        end
        w_th     = w_near ? r_mh : r_held;
        w_ke_mag = (r_ke < 0) ? 48'(-r_ke) : 48'(r_ke);
    end

    // divider step, cordic step and atan rounding
    always_comb begin
        w_rsh = {r_dr, r_dn[51]};
        w_dge = w_rsh >= {1'b0, r_dd};
        if (r_cy < 0) begin
            w_ys = -((-r_cy) >>> r_ci);
        end else begin
            w_ys = r_cy >>> r_ci;
        end
        w_xs  = r_cx >>> r_ci;
        w_ang = signed'({3'b000, cordic_angle(r_ci)});
        w_zc  = (r_cz < 0) ? '0 : r_cz;
        w_atm = 15'((w_zc + 19'sd8) >>> 4);
    end

    // steering clamp, speed gate and exponential helpers
    always_comb begin
        w_hsum = 18'(r_he) + 18'(r_at);
        w_lim  = 35'(signed'({1'b0, r_steer_lim, 8'b0}));
        if (r_p > w_lim) begin
            w_omega = signed'({1'b0, r_steer_lim});
        end else if (r_p < -w_lim) begin
            w_omega = -signed'({1'b0, r_steer_lim});
        end else if (r_p < 0) begin
            w_omega = -16'((-r_p) >>> 8);
        end else begin
            w_omega = 16'(r_p >>> 8);
        end
        w_ahe        = (r_he < 0) ? 17'(-r_he) : 17'(r_he);
        w_speed_zero = (w_ahe >= 17'(PI_Q12)) || (r_elapsed == '0);
        w_xexp       = 17'(w_ahe * 17'd10);
        w_tprod      = 45'(r_term) * 45'(r_f);
        w_term_s     = signed'({2'b00, r_dn[32:0]});
        w_einv       = 65'(r_kv) * 65'(EINV_Q32) + (65'(1) << 31);
        w_spd        = 53'(r_sa) + 53'(r_pb[64:32]);
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_pose_go) n_state = S_DIFF;
            S_DIFF:  n_state = S_SQX;
            S_SQX:   n_state = S_SQY;
            S_SQY:   n_state = S_SQSUM;
            S_SQSUM: n_state = S_SQRT;
            S_SQRT:  if (r_cnt == 6'd1) n_state = S_DIST;
            S_DIST:  n_state = S_POST;
            S_POST:  n_state = S_KE;
            S_KE:    n_state = (r_speed_ref == '0) ? S_STEER : S_DIV;
            S_DIV:   if (r_cnt == 6'd1) n_state = r_ret;
            S_CINIT: n_state = S_CORD;
            S_CORD:  if (r_ci == CORDIC_LAST) n_state = S_CATAN;
            S_CATAN: n_state = S_STEER;
            S_STEER: n_state = S_CLAMP;
            S_CLAMP: n_state = w_speed_zero ? S_DONE : S_QMUL;
            S_QMUL:  n_state = S_DIV;
            S_EXP0:  n_state = S_TMUL;
            S_TMUL:  n_state = S_DIV;
            S_TACC:  n_state = (r_k == TAYLOR_LAST) ? S_EXPN : S_TMUL;
            S_EXPN:  n_state = S_EINV;
            S_EINV:  if (r_cnt == '0 || r_kv == '0) n_state = S_SPD1;
            S_SPD1:  n_state = S_SPD2;
            S_SPD2:  n_state = S_SPD3;
            S_SPD3:  n_state = S_DONE;
            S_DONE:  if (!r_ovalid) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // path store: load words write, pose words read the current waypoint;
    // one word at a time so a read never overlaps a write to the same slot
    always_ff @(posedge i_clk) begin
        if (w_load_wr) begin
            r_path_x[PTR_W'(i_load_index)] <= i_point_x;
            r_path_y[PTR_W'(i_load_index)] <= i_point_y;
            r_path_h[PTR_W'(i_load_index)] <= i_point_heading;
        end
        if (w_pose_go) begin
            r_mx <= signed'(r_path_x[w_idx]);
            r_my <= signed'(r_path_y[w_idx]);
            r_mh <= signed'(r_path_h[w_idx]);
        end
    end

    // sequencer, datapath and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_ret        <= S_IDLE;
            r_cnt        <= '0;
            r_ci         <= '0;
            r_k          <= '0;
            r_ptr        <= '0;
            r_held       <= '0;
            r_ovalid     <= 1'b0;
            r_path_len   <= 9'd0;
            r_ct_gain    <= 16'd26;
            r_speed_ref  <= 16'd51;
            r_steer_gain <= 16'd2560;
            r_reach      <= 31'd13107;
            r_steer_lim  <= 15'd3277;
        end else begin
            r_state <= n_state;

            // configuration writes
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_PATH_LEN:   r_path_len   <= i_cfg_data[8:0];
                    CFG_CT_GAIN:    r_ct_gain    <= i_cfg_data[15:0];
                    CFG_SPEED_REF:  r_speed_ref  <= i_cfg_data[15:0];
                    CFG_STEER_GAIN: r_steer_gain <= i_cfg_data[15:0];
                    CFG_REACH:      r_reach      <= i_cfg_data;
                    CFG_STEER_LIM:  r_steer_lim  <= i_cfg_data[14:0];
                    default:        ;
                endcase
            end

            // result word taken downstream
            if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                // latch the pose and the robot position in the world frame
                S_IDLE: begin
                    if (w_pose_go) begin
                        r_idx     <= w_idx;
                        r_rx      <= 33'(i_odom_x) + 33'(i_frame_offset_x);
                        r_ry      <= 33'(i_odom_y) + 33'(i_frame_offset_y);
                        r_offy    <= i_frame_offset_y;
                        r_rhead   <= i_robot_heading;
                        r_elapsed <= i_elapsed_us;
                    end
                end
                // coordinate differences and error sign
                S_DIFF: begin
                    r_ax   <= abs_sat31(34'(r_mx) - 34'(r_rx));
                    r_ay   <= abs_sat31(34'(r_my) - 34'(r_ry));
                    r_negy <= (33'(r_my) - 33'(r_offy)) < 0;
                end
                S_SQX: r_prod <= 62'(r_ax) * 62'(r_ax);
                S_SQY: begin
                    r_acc  <= 63'(r_prod);
                    r_prod <= 62'(r_ay) * 62'(r_ay);
                end
                S_SQSUM: begin
                    r_acc <= r_acc + 63'(r_prod);
                    r_res <= '0;
                    r_bit <= 64'd1 << 62;
                    r_cnt <= 6'd32;
                end
                // one result bit a cycle
                S_SQRT: begin
                    if (w_sq_ge) begin
                        r_acc <= 63'({1'b0, r_acc} - w_trial);
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    r_cnt <= r_cnt - 6'd1;
                end
                S_DIST: r_dist <= (r_res > 64'(SAT31)) ? SAT31 : r_res[30:0];
                // waypoint advance, held heading, error and gain product
                S_POST: begin
                    r_ptr <= w_reach ? w_nxt[PTR_W-1:0] : r_idx;
                    if (w_near) begin
                        r_held <= r_mh;
                    end
                    r_e  <= w_e;
                    r_he <= 17'(w_th) - 17'(r_rhead);
                    r_ke <= 49'(signed'({1'b0, r_ct_gain}) * w_e);
                end
                // start the divide for the atan argument, or set the angle directly when the speed reference is zero
                S_KE: begin
                    if (r_speed_ref == '0) begin
                        if (r_ke > 0) begin
                            r_at <= HALF_PI_Q12;
                        end else if (r_ke < 0) begin
                            r_at <= -HALF_PI_Q12;
                        end else begin
                            r_at <= '0;
                        end
                    end else begin
                        r_dn     <= {w_ke_mag, 4'b0};
                        r_dr     <= '0;
                        r_dd     <= 20'(r_speed_ref);
                        r_cnt    <= 6'd48;
                        r_ret    <= S_CINIT;
                        r_argneg <= r_ke < 0;
                    end
                end
                // shared restoring divider, one quotient bit a cycle
                S_DIV: begin
                    r_dr  <= w_dge ? 20'(w_rsh - {1'b0, r_dd}) : w_rsh[19:0];
                    r_dn  <= {r_dn[50:0], w_dge};
                    r_cnt <= r_cnt - 6'd1;
                end
                S_CINIT: begin
                    r_cx     <= 50'sd65536;
                    r_cy     <= signed'(50'(r_dn[47:0]));
                    r_cz     <= '0;
                    r_ci     <= '0;
                    r_argneg <= r_argneg & (r_dn[47:0] != '0);
                end
                // cordic vectoring, one rotation a cycle
                S_CORD: begin
                    if (r_cy >= 0) begin
                        r_cx <= r_cx + w_ys;
                        r_cy <= r_cy - w_xs;
                        r_cz <= r_cz + w_ang;
                    end else begin
                        r_cx <= r_cx - w_ys;
                        r_cy <= r_cy + w_xs;
                        r_cz <= r_cz - w_ang;
                    end
                    r_ci <= r_ci + 5'd1;
                end
                S_CATAN: begin
                    r_at <= r_argneg ? -signed'({1'b0, w_atm}) : signed'({1'b0, w_atm});
                end
                S_STEER: r_p <= 35'(signed'({1'b0, r_steer_gain}) * w_hsum);
                S_CLAMP: begin
                    r_omega <= w_omega;
                    if (w_speed_zero) begin
                        r_speed <= '0;
                    end
                end
                // distance over time
                S_QMUL: begin
                    r_dn  <= {51'(r_dist) * 51'(USEC_PER_SEC), 1'b0};
                    r_dr  <= '0;
                    r_dd  <= r_elapsed;
                    r_cnt <= 6'd51;
                    r_ret <= S_EXP0;
                end
                // exp of minus ten times the heading error
                S_EXP0: begin
                    r_q    <= r_dn[50:0];
                    r_n    <= w_xexp[16:12];
                    r_f    <= w_xexp[11:0];
                    r_term <= 33'd1 << 32;
                    r_sum  <= 35'sd1 <<< 32;
                    r_k    <= 5'd1;
                end
                S_TMUL: begin
                    r_dn  <= {w_tprod[44:12], 19'b0};
                    r_dr  <= '0;
                    r_dd  <= 20'(r_k);
                    r_cnt <= 6'd33;
                    r_ret <= S_TACC;
                end
                S_TACC: begin
                    r_term <= r_dn[32:0];
                    r_sum  <= r_k[0] ? (r_sum - w_term_s) : (r_sum + w_term_s);
                    r_k    <= r_k + 5'd1;
                end
                S_EXPN: begin
                    if (r_sum < 0) begin
                        r_kv <= '0;
                    end else if (r_sum > (35'sd1 <<< 32)) begin
                        r_kv <= 33'd1 << 32;
                    end else begin
                        r_kv <= r_sum[32:0];
                    end
                    r_cnt <= 6'(r_n);
                end
                // one factor of 1/e per integer unit
                S_EINV: begin
                    if (r_cnt != '0 && r_kv != '0) begin
                        r_kv  <= w_einv[64:32];
                        r_cnt <= r_cnt - 6'd1;
                    end
                end
                S_SPD1: r_sa <= 52'(r_q[50:32]) * 52'(r_kv);
                S_SPD2: r_pb <= 65'(r_q[31:0]) * 65'(r_kv);
                S_SPD3: r_speed <= (w_spd > 53'(SAT31)) ? SAT31 : w_spd[30:0];
                // hand the result word over
                S_DONE: begin
                    if (!r_ovalid) begin
                        r_ovalid  <= 1'b1;
                        r_o_steer <= r_omega;
                        r_o_speed <= r_speed;
                        r_o_ct    <= r_e;
                        r_o_idx   <= 8'(r_idx);
                    end
                end
                default: ;
            endcase
        end
    end

    // checks
    `SPT_ASSERT_IMP(a_done_load, i_clk, i_rst_n, $rose(r_ovalid), $past(r_state) == S_DONE, "result loaded outside done state")
    `SPT_ASSERT_IMP(a_div_count, i_clk, i_rst_n, r_state == S_DIV, r_cnt != 6'd0, "divider running with empty count")
    `SPT_ASSERT_NXT(a_pose_start, i_clk, i_rst_n, w_pose_go, r_state == S_DIFF, "pose word did not start sequencer")

endmodule
